### rtl/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg: shared definitions for the sliding window minimum block
// Holds the configuration register width and the control state encoding.
// ----------------------------------------------------------------------------
package swm_pkg;

  // Width of the window size configuration register.
  localparam int CFG_W = 9;

  // Control sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,  // waiting for a sample
    ST_SCAN = 4'b0010,  // expire front entries, first back compare
    ST_BACK = 4'b0100,  // drop back entries greater than the sample
    ST_PUSH = 4'b1000   // append the sample and emit the minimum
  } state_t;

endpackage

### rtl/sliding_window_minimum.sv
// ----------------------------------------------------------------------------
// sliding_window_minimum: minimum over the most recent window of samples
// Keeps a monotonic deque of (value, position) pairs in a ring buffer memory.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Signals                         Payload
//  s_*       in         s_tvalid s_tready s_tdata       sample
//  m_*       out        m_tvalid m_tready m_tdata       window_min
//  cfg_*     in         cfg_valid cfg_ready cfg_data    window_size
//
// A sample is accepted in the idle state and then passes through the scan
// state and the push state; with an empty deque the scan is skipped. Every
// entry that expires from the front or is dropped from the back adds a
// further scan or back step, except the expiry or drop that empties the
// deque. Each drop needs a fresh registered read of the deque memory.
// Every sample is dropped at most once, and samples are accepted only in idle.
// Reset (rst, synchronous) empties the deque and sets the window to 1; the
// memory itself needs no clearing. A result that waits on m_tready holds the
// next sample in the push step; no further sample is accepted meanwhile.
//
module sliding_window_minimum
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX   = 256,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Sample stream; tdata: sample
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_tdata,
  // Result stream; tdata: window_min
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     m_tdata,
  // Window size register write
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [CFG_W-1:0]                      cfg_data
);

  localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int PTR_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int POS_W  = $clog2(2 * WINDOW_MAX);
  localparam int CMP_W  = ((POS_W > CFG_W) ? POS_W : CFG_W) + 1;
  localparam int ENT_W  = SAMPLE_WIDTH + POS_W;

  // Ring index wrap for sums of two indexes below WINDOW_MAX.
  function automatic logic [PTR_W-1:0] wrap_ptr(input logic [PTR_W:0] v);
    logic [PTR_W:0] r;
    r = v;
    if (v >= (PTR_W+1)'(WINDOW_MAX)) begin
      r = v - (PTR_W+1)'(WINDOW_MAX);
    end
    return r[PTR_W-1:0];
  endfunction

  state_t                  state, state_next;
  logic [PTR_W-1:0]        head, head_next;
  logic [CNT_W-1:0]        count, count_next;
  logic [POS_W-1:0]        item_pos, item_pos_next;
  logic [CFG_W-1:0]        window_size;
  logic [SAMPLE_WIDTH-1:0] sample, sample_next;
  logic [SAMPLE_WIDTH-1:0] window_min, window_min_next;
  logic                    out_valid, out_valid_next;

  logic                    mem_we;
  logic [PTR_W-1:0]        mem_waddr;
  logic [ENT_W-1:0]        mem_wdata;
  logic [PTR_W-1:0]        rd_head_addr, rd_tail_addr;
  logic [ENT_W-1:0]        rd_head, rd_tail;

  logic [SAMPLE_WIDTH-1:0] head_value, tail_value;
  logic [POS_W-1:0]        head_pos, age;
  logic [POS_W:0]          age_sum;
  logic [CMP_W-1:0]        win_eff, ws_ext;
  logic                    expired, back_greater, out_free;
  logic [CNT_W-1:0]        count_push;

  assign head_value = rd_head[SAMPLE_WIDTH-1:0];
  assign head_pos   = rd_head[ENT_W-1:SAMPLE_WIDTH];
  assign tail_value = rd_tail[SAMPLE_WIDTH-1:0];

  // Effective window: zero acts as one, large values saturate.
  assign ws_ext = CMP_W'(window_size);
  always_comb begin
    if (window_size == '0) begin
      win_eff = CMP_W'(1);
    end else if (ws_ext > CMP_W'(WINDOW_MAX)) begin
      win_eff = CMP_W'(WINDOW_MAX);
    end else begin
      win_eff = ws_ext;
    end
  end

  // Age of the front entry, positions counted modulo twice the depth.
  always_comb begin
    if (item_pos >= head_pos) begin
      age_sum = {1'b0, item_pos} - {1'b0, head_pos};
    end else begin
      age_sum = {1'b0, item_pos} + (POS_W+1)'(2 * WINDOW_MAX) - {1'b0, head_pos};
    end
  end
  assign age     = age_sum[POS_W-1:0];
  assign expired = CMP_W'(age) >= win_eff;

  assign back_greater = $signed(tail_value) > $signed(sample);
  assign out_free     = !out_valid || m_tready;
  assign count_push   = (count >= CNT_W'(WINDOW_MAX)) ? CNT_W'(WINDOW_MAX - 1) : count;

  // Sequencer: expire from the front, drop from the back, then push.
  always_comb begin
    state_next      = state;
    head_next       = head;
    count_next      = count;
    item_pos_next   = item_pos;
    sample_next     = sample;
    window_min_next = window_min;
    out_valid_next  = out_valid && !m_tready;
    mem_we          = 1'b0;
    mem_waddr       = wrap_ptr((PTR_W+1)'(head) + (PTR_W+1)'(count_push));
    mem_wdata       = {item_pos, sample};
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          sample_next = s_tdata[SAMPLE_WIDTH-1:0];
          state_next  = (count == '0) ? ST_PUSH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (expired) begin
          head_next  = wrap_ptr((PTR_W+1)'(head) + (PTR_W+1)'(1));
          count_next = count - CNT_W'(1);
          state_next = (count == CNT_W'(1)) ? ST_PUSH : ST_SCAN;
        end else if (back_greater) begin
          count_next = count - CNT_W'(1);
          state_next = (count == CNT_W'(1)) ? ST_PUSH : ST_BACK;
        end else begin
          state_next = ST_PUSH;
        end
      end
      ST_BACK: begin
        if (back_greater) begin
          count_next = count - CNT_W'(1);
          state_next = (count == CNT_W'(1)) ? ST_PUSH : ST_BACK;
        end else begin
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          mem_we          = 1'b1;
          count_next      = count_push + CNT_W'(1);
          window_min_next = (count == '0) ? sample : head_value;
          out_valid_next  = 1'b1;
          item_pos_next   = (item_pos == POS_W'(2 * WINDOW_MAX - 1)) ?
                            '0 : item_pos + POS_W'(1);
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Reads follow the next front and back so data is ready in the following cycle.
  assign rd_head_addr = head_next;
  assign rd_tail_addr = wrap_ptr((PTR_W+1)'(head_next) + (PTR_W+1)'(count_next)
                                 - (PTR_W+1)'(1));

  swm_ram #(
    .DEPTH  (WINDOW_MAX),
    .WIDTH  (ENT_W),
    .ADDR_W (PTR_W)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (rd_head_addr),
    .rdata_a (rd_head),
    .raddr_b (rd_tail_addr),
    .rdata_b (rd_tail)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      head        <= '0;
      count       <= '0;
      item_pos    <= '0;
      out_valid   <= 1'b0;
      window_size <= CFG_W'(1);
    end else begin
      state     <= state_next;
      head      <= head_next;
      count     <= count_next;
      item_pos  <= item_pos_next;
      out_valid <= out_valid_next;
      if (cfg_valid) begin
        window_size <= cfg_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    sample     <= sample_next;
    window_min <= window_min_next;
  end

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = DATA_W'(window_min);

endmodule

### rtl/swm_ram.sv
// ----------------------------------------------------------------------------
// swm_ram: deque storage for the sliding window minimum block
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module swm_ram #(
  parameter int DEPTH  = 256,
  parameter int WIDTH  = 41,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  output logic [WIDTH-1:0]  rdata_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [WIDTH-1:0]  rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Two registered read ports; a read at the written address returns old data.
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
